// ===== sv/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Operation codes and shared control types for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } fpa_op_t;

  // Control that rides along each pipeline slot
  typedef struct packed {
    logic vld;
    logic is_div;
    logic neg;
    logic dz;
    logic flag;
  } fpa_ctl_t;

endpackage

// ===== sv/fpa_in_if.sv =====
// ----------------------------------------------------------------------------
// fpa_in_if
// Operation channel: opcode and two raw fixed-point operands.
// ----------------------------------------------------------------------------
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

// ===== sv/fpa_out_if.sv =====
// ----------------------------------------------------------------------------
// fpa_out_if
// Result channel: raw value, compare flag and divide-by-zero flag.
// ----------------------------------------------------------------------------
interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               flag;
  logic               div_by_zero;

  modport source (output valid, value, flag, div_by_zero, input ready);
  modport sink   (input valid, value, flag, div_by_zero, output ready);
endinterface

// ===== sv/fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point ALU with a cell-per-bit divider chain.
// ----------------------------------------------------------------------------
// Takes one operation per cycle and returns one result per operation, in
// order. Every operation takes the same path from input transfer to a valid
// result: one entry stage, a chain of 32 + FRACTION_BITS division cells
// (one quotient bit each) and an output register. The whole pipeline holds
// while a result waits on the output.
module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input logic   clk,
  input logic   rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);

  localparam int unsigned DW = 32 + FRACTION_BITS;
  localparam int unsigned NC = DW;

  logic en;

  fpa_ctl_t      ctl_c [NC+1];
  logic [31:0]   res_c [NC+1];
  logic [31:0]   rem_c [NC+1];
  logic [DW-1:0] dvd_c [NC+1];
  logic [31:0]   mb_c  [NC+1];
  logic [31:0]   q_c   [NC+1];

  logic        out_vld_r;
  logic [31:0] out_val_r, out_val_nxt;
  logic        out_flag_r, out_dz_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  fpa_prep #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_ch.valid),
    .action    (in_ch.action),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .ctl_o     (ctl_c[0]),
    .res_o     (res_c[0]),
    .dvd_o     (dvd_c[0]),
    .mb_o      (mb_c[0])
  );

  assign rem_c[0] = '0;
  assign q_c[0]   = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fpa_div_cell #(.DW(DW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_c[i]),
      .res_i (res_c[i]),
      .rem_i (rem_c[i]),
      .dvd_i (dvd_c[i]),
      .mb_i  (mb_c[i]),
      .q_i   (q_c[i]),
      .ctl_o (ctl_c[i+1]),
      .res_o (res_c[i+1]),
      .rem_o (rem_c[i+1]),
      .dvd_o (dvd_c[i+1]),
      .mb_o  (mb_c[i+1]),
      .q_o   (q_c[i+1])
    );
  end

  always_comb begin
    priority if (!ctl_c[NC].is_div) begin
      out_val_nxt = res_c[NC];
    end else if (ctl_c[NC].dz) begin
      out_val_nxt = '0;
    end else if (ctl_c[NC].neg) begin
      out_val_nxt = 32'(-q_c[NC]);
    end else begin
      out_val_nxt = q_c[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_c[NC].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r  <= out_val_nxt;
      out_flag_r <= ctl_c[NC].flag;
      out_dz_r   <= ctl_c[NC].is_div && ctl_c[NC].dz;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.value       = out_val_r;
  assign out_ch.flag        = out_flag_r;
  assign out_ch.div_by_zero = out_dz_r;

endmodule

// ===== sv/fpa_prep.sv =====
// ----------------------------------------------------------------------------
// fpa_prep
// Entry stage: evaluates every operation but divide and sets up the divider.
// ----------------------------------------------------------------------------
module fpa_prep
  import fpa_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned DW            = 32 + FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [3:0]         action,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output fpa_ctl_t           ctl_o,
  output logic [31:0]        res_o,
  output logic [DW-1:0]      dvd_o,
  output logic [31:0]        mb_o
);

  fpa_ctl_t           ctl_r, ctl_nxt;
  logic [31:0]        res_r, res_nxt;
  logic [DW-1:0]      dvd_r, dvd_nxt;
  logic [31:0]        mb_r, mb_nxt;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic signed [31:0] a_sh;
  logic [31:0]        ma;
  fpa_op_t            op;

  always_comb begin
    op      = fpa_op_t'(action);
    prod    = 64'(operand_a) * 64'(operand_b);
    prod_sh = prod >>> FRACTION_BITS;
    a_sh    = operand_a >>> FRACTION_BITS;
    ma      = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
    mb_nxt  = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);
    dvd_nxt = DW'(ma) << FRACTION_BITS;
    res_nxt = '0;
    ctl_nxt = '0;
    ctl_nxt.vld = in_vld;
    unique case (op)
      OP_ADD:      res_nxt = 32'(operand_a + operand_b);
      OP_SUB:      res_nxt = 32'(operand_a - operand_b);
      OP_MUL:      res_nxt = prod_sh[31:0];
      OP_DIV: begin
        ctl_nxt.is_div = 1'b1;
        ctl_nxt.neg    = operand_a[31] ^ operand_b[31];
        ctl_nxt.dz     = (operand_b == '0);
      end
      OP_GT:       ctl_nxt.flag = operand_a >  operand_b;
      OP_LT:       ctl_nxt.flag = operand_a <  operand_b;
      OP_GE:       ctl_nxt.flag = operand_a >= operand_b;
      OP_LE:       ctl_nxt.flag = operand_a <= operand_b;
      OP_EQ:       ctl_nxt.flag = operand_a == operand_b;
      OP_NE:       ctl_nxt.flag = operand_a != operand_b;
      OP_MIN:      res_nxt = (operand_a < operand_b) ? operand_a : operand_b;
      OP_MAX:      res_nxt = (operand_a > operand_b) ? operand_a : operand_b;
      OP_INC:      res_nxt = 32'(operand_a + 32'sd1);
      OP_DEC:      res_nxt = 32'(operand_a - 32'sd1);
      OP_FROM_INT: res_nxt = 32'(operand_a << FRACTION_BITS);
      OP_TO_INT:   res_nxt = a_sh;
      default:     res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      dvd_r <= dvd_nxt;
      mb_r  <= mb_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign res_o = res_r;
  assign dvd_o = dvd_r;
  assign mb_o  = mb_r;

endmodule

// ===== sv/fpa_div_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division step; also carries the finished result of other ops.
// ----------------------------------------------------------------------------
module fpa_div_cell
  import fpa_pkg::*;
#(
  parameter int unsigned DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  fpa_ctl_t      ctl_i,
  input  logic [31:0]   res_i,
  input  logic [31:0]   rem_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [31:0]   mb_i,
  input  logic [31:0]   q_i,
  output fpa_ctl_t      ctl_o,
  output logic [31:0]   res_o,
  output logic [31:0]   rem_o,
  output logic [DW-1:0] dvd_o,
  output logic [31:0]   mb_o,
  output logic [31:0]   q_o
);

  fpa_ctl_t      ctl_r;
  logic [31:0]   res_r, mb_r, rem_r, rem_nxt, q_r, q_nxt;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [32:0]   trial, diff;
  logic          ge;

  always_comb begin
    trial   = {rem_i, dvd_i[DW-1]};
    diff    = trial - {1'b0, mb_i};
    ge      = (trial >= {1'b0, mb_i});
    // remainder stays below the divisor, so 32 bits hold it
    rem_nxt = ge ? diff[31:0] : trial[31:0];
    dvd_nxt = {dvd_i[DW-2:0], 1'b0};
    q_nxt   = {q_i[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_i;
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      mb_r  <= mb_i;
      q_r   <= q_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign res_o = res_r;
  assign rem_o = rem_r;
  assign dvd_o = dvd_r;
  assign mb_o  = mb_r;
  assign q_o   = q_r;

endmodule

// ===== tb/sv/fixed_point_alu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_checker
// Watches the operation and result channels, predicts each result of the
// fixed-point ALU and compares it field by field against what comes out.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker
  import fpa_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  fpa_in_if.sink   in_mon,
  fpa_out_if.sink  out_mon,
  output int       fail_count,
  output int       pending_count
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               flag;
    logic               div_by_zero;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic alu_result_t compute_result(fpa_op_t op, logic signed [31:0] a,
                                                 logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] prod;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] quot;
    r = '0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        prod = 64'(a) * 64'(b);
        prod = prod >>> FRACTION_BITS;
        r.value = prod[31:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          mag_a = a < 0 ? -64'(a) : 64'(a);
          mag_b = b < 0 ? -64'(b) : 64'(b);
          quot = (mag_a << FRACTION_BITS) / mag_b;
          if ((a < 0) != (b < 0)) quot = -quot;
          r.value = quot[31:0];
        end
      end
      OP_GT: r.flag = a > b;
      OP_LT: r.flag = a < b;
      OP_GE: r.flag = a >= b;
      OP_LE: r.flag = a <= b;
      OP_EQ: r.flag = a == b;
      OP_NE: r.flag = a != b;
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: r.value = a + 1;
      OP_DEC: r.value = a - 1;
      OP_FROM_INT: r.value = a << FRACTION_BITS;
      default: r.value = a >>> FRACTION_BITS;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    int errs;
    errs = 0;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer value=%0d", out_mon.value);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, out_mon.value);
            errs++;
          end
          if (out_mon.flag !== want.flag) begin
            $error("flag: expected %0b, actual %0b", want.flag, out_mon.flag);
            errs++;
          end
          if (out_mon.div_by_zero !== want.div_by_zero) begin
            $error("div_by_zero: expected %0b, actual %0b", want.div_by_zero,
                   out_mon.div_by_zero);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(compute_result(fpa_op_t'(in_mon.action),
                                                  in_mon.operand_a, in_mon.operand_b));
    end
    if (errs != 0) fail_count <= fail_count + errs;
    pending_count <= expected_results.size();
  end

  initial fail_count = 0;

endmodule

// ===== tb/sv/fixed_point_alu_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_tb
// Directed corner operations, then bursty random traffic against a receiver
// that stalls; results are checked in order by the companion checker.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int RandomItems = 1800;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;

  fpa_in_if  in_ch ();
  fpa_out_if out_ch ();

  fixed_point_alu #(.FRACTION_BITS(FRACTION_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  fixed_point_alu_checker #(.FRACTION_BITS(FRACTION_BITS)) i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern: alternate free-flowing and choppy stretches
  int stall_phase;
  initial begin
    out_ch.ready = 1'b0;
    stall_phase = 0;
  end
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (stall_phase < 100) out_ch.ready <= 1'b1;
    else if (stall_phase < 200) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 2) == 0);
  end

  logic signed [31:0] corner_vals[8] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1,
                                         32'sh0000_0100, -32'sh0000_0100, 32'sh0001_0080};

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(0, 4))
      0: return corner_vals[$urandom_range(0, 7)];
      1: return $signed(32'($urandom_range(0, 2047))) - 1024;
      default: return $signed($urandom());
    endcase
  endfunction

  int burst_left;

  task automatic send_op(fpa_op_t op, logic signed [31:0] a, logic signed [31:0] b);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.action    <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    rst_n = 1'b0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation on extremes, zero divisor, equal operands
    for (int op = 0; op < 16; op++)
      send_op(fpa_op_t'(op), corner_vals[op % 8], corner_vals[(op + 3) % 8]);
    send_op(OP_DIV, 32'sh7fff_ffff, 0);
    send_op(OP_DIV, 32'sh8000_0000, -1);
    send_op(OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
    send_op(OP_MIN, 5, 5);
    send_op(OP_MAX, -7, -7);
    send_op(OP_EQ, -3, -3);
    send_op(OP_TO_INT, -1, 0);
    send_op(OP_INC, 32'sh7fff_ffff, 0);
    send_op(OP_DEC, 32'sh8000_0000, 0);

    // Hold off until the pipeline has fully drained
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    for (int i = 0; i < RandomItems; i++) begin
      logic signed [31:0] a;
      logic signed [31:0] b;
      a = rand_operand();
      b = ($urandom_range(0, 19) == 0) ? 0 : rand_operand();
      if ($urandom_range(0, 9) == 0) b = a;
      send_op(fpa_op_t'($urandom_range(0, 15)), a, b);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending_count != 0) @(posedge clk);
    repeat (FRACTION_BITS + 60) @(posedge clk);
    if (fail_count == 0) begin
      $display("[fixed_point_alu] OK");
    end else begin
      $display("[fixed_point_alu] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[fixed_point_alu] ERROR");
    $finish;
  end

endmodule

// ===== fixed_point_alu.f =====
sv/fpa_pkg.sv
sv/fpa_in_if.sv
sv/fpa_out_if.sv
sv/fpa_prep.sv
sv/fpa_div_cell.sv
sv/fixed_point_alu.sv
tb/sv/fixed_point_alu_checker.sv
tb/sv/fixed_point_alu_tb.sv
